// ===== hdl/lfu_pkg.sv =====
package lfu_pkg;

  // Built slot count; the slot index is just wide enough for it
  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W = 31;
  localparam int DAT_W = 32;
  localparam int CNT_W = 32;
  localparam int STP_W = 32;
  localparam int CAP_W = 5;

  localparam logic [DAT_W-1:0] MISS_DATA = '1;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_SET = 1'b1
  } mode_t;

  // Running result handed from cell to cell during a scan
  typedef struct packed {
    logic              found;
    idx_t              where;
    logic [DAT_W-1:0]  hit_data;
    logic              empty_found;
    idx_t              empty_idx;
    logic              best_valid;
    logic [CNT_W-1:0]  best_cnt;
    logic [STP_W-1:0]  best_stamp;
    idx_t              best_idx;
  } carry_t;

  // Update broadcast to all cells at the end of an item
  typedef struct packed {
    logic              en;
    idx_t              idx;
    logic              fill;
    logic              wr_data;
    logic [KEY_W-1:0]  key;
    logic [DAT_W-1:0]  value;
    logic [STP_W-1:0]  stamp;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/lfu_cell.sv =====
module lfu_cell import lfu_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_use,
  input  logic [KEY_W-1:0] key,
  input  logic             wave_in,
  input  carry_t           carry_in,
  output logic             wave_out,
  output carry_t           carry_out,
  input  cmd_t             cmd
);

  localparam idx_t MY_IDX = IDX_W'(IDX);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [DAT_W-1:0] data_r, data_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STP_W-1:0] stamp_r, stamp_nxt;
  logic             wave_r;
  carry_t           carry_r, carry_nxt;
  logic             match, empty, better;

  assign match  = in_use && valid_r && (key_r == key) && !carry_in.found;
  assign empty  = in_use && !valid_r && !carry_in.empty_found;
  // strict compare keeps the lower index on a full tie
  assign better = in_use && valid_r &&
                  (!carry_in.best_valid || (cnt_r < carry_in.best_cnt) ||
                   ((cnt_r == carry_in.best_cnt) && (stamp_r < carry_in.best_stamp)));

  always_comb begin
    carry_nxt = carry_in;
    if (match) begin
      carry_nxt.found    = 1'b1;
      carry_nxt.where    = MY_IDX;
      carry_nxt.hit_data = data_r;
    end
    if (empty) begin
      carry_nxt.empty_found = 1'b1;
      carry_nxt.empty_idx   = MY_IDX;
    end
    if (better) begin
      carry_nxt.best_valid = 1'b1;
      carry_nxt.best_cnt   = cnt_r;
      carry_nxt.best_stamp = stamp_r;
      carry_nxt.best_idx   = MY_IDX;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    cnt_nxt   = cnt_r;
    stamp_nxt = stamp_r;
    if (cmd.en && (cmd.idx == MY_IDX)) begin
      stamp_nxt = cmd.stamp;
      if (cmd.fill) begin
        valid_nxt = 1'b1;
        key_nxt   = cmd.key;
        data_nxt  = cmd.value;
        cnt_nxt   = CNT_W'(1);
      end else begin
        if (cnt_r != CNT_MAX) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (cmd.wr_data) begin
          data_nxt = cmd.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wave_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      wave_r  <= wave_in;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    data_r  <= data_nxt;
    cnt_r   <= cnt_nxt;
    stamp_r <= stamp_nxt;
    if (wave_in) begin
      carry_r <= carry_nxt;
    end
  end

  assign wave_out  = wave_r;
  assign carry_out = carry_r;

endmodule

// ===== hdl/lfu_cache_lru_tiebreak.sv =====
// Fully associative key/value cache with least-frequently-used replacement and
// oldest-stamp tie-break. Each slot lives in its own cell; a lookup is a wave
// that walks the row of cells one cell per clock, gathering the first key
// match, the first empty slot in use and the eviction candidate. The result of
// an item is registered once the wave has left the last cell of the row, plus
// any wait on out_stall; the next item is taken only once the result is loaded,
// so a new item is never taken while one is in flight. ENTRIES is the built slot
// count (package). Capacity (cfg_data) selects how many of the first slots are
// searched and replaced: 0 counts as 1, values above ENTRIES as ENTRIES. Write
// capacity only while no item is in flight.
module lfu_cache_lru_tiebreak import lfu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [DAT_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic signed [DAT_W-1:0] out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data
);

  localparam int NW = ($clog2(ENTRIES + 1) > CAP_W) ? $clog2(ENTRIES + 1) : CAP_W;
  localparam logic [NW-1:0] ENTRIES_N = NW'(ENTRIES);

  state_t           state_r, state_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [NW-1:0]    cap_ext, n_used;
  logic [ENTRIES-1:0] in_use;
  mode_t            mode_r;
  logic [KEY_W-1:0] key_r;
  logic [DAT_W-1:0] value_r;
  logic [STP_W-1:0] stamp_r;
  logic             launch_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r;
  logic [DAT_W-1:0] out_data_r;
  logic             accept, out_free, commit;
  carry_t           fin;
  cmd_t             cmd;
  logic             wave_w  [0:ENTRIES];
  carry_t           carry_w [0:ENTRIES];

  assign cfg_ready = 1'b1;

  assign cap_ext = NW'(cap_r);
  always_comb begin
    n_used = cap_ext;
    if (cap_ext == '0) begin
      n_used = NW'(1);
    end else if (cap_ext > ENTRIES_N) begin
      n_used = ENTRIES_N;
    end
  end

  assign wave_w[0]  = launch_r;
  assign carry_w[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign in_use[i] = (NW'(i) < n_used);
    lfu_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_use    (in_use[i]),
      .key       (key_r),
      .wave_in   (wave_w[i]),
      .carry_in  (carry_w[i]),
      .wave_out  (wave_w[i+1]),
      .carry_out (carry_w[i+1]),
      .cmd       (cmd)
    );
  end

  assign fin      = carry_w[ENTRIES];
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (wave_w[ENTRIES]) begin
          if (out_free) begin
            commit    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Slot update: touch on a hit (also writing the value on a set hit), fill on a set miss, nothing on a get miss
  always_comb begin
    cmd.en      = commit && (fin.found || (mode_r == MODE_SET));
    cmd.fill    = !fin.found;
    cmd.wr_data = (mode_r == MODE_SET);
    cmd.key     = key_r;
    cmd.value   = value_r;
    cmd.stamp   = stamp_r + STP_W'(1);
    if (fin.found) begin
      cmd.idx = fin.where;
    end else if (fin.empty_found) begin
      cmd.idx = fin.empty_idx;
    end else begin
      cmd.idx = fin.best_idx;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_W'(16);
      stamp_r     <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= accept;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (cmd.en) begin
        stamp_r <= cmd.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= mode_t'(in_mode);
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (commit) begin
      out_hit_r <= fin.found;
      if (mode_r == MODE_SET) begin
        out_data_r <= '0;
      end else if (fin.found) begin
        out_data_r <= fin.hit_data;
      end else begin
        out_data_r <= MISS_DATA;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_data  = out_data_r;

endmodule
